// File: rtl/aks_pkg.sv
`default_nettype none
package aks_pkg;

  // Schedule geometry
  localparam int unsigned KEY_WORDS   = 4;
  localparam int unsigned SCHED_WORDS = 44;
  localparam int unsigned IDX_W       = 6;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCHED_WORDS - 1);

  // Round constant seed and reduction polynomial (low byte)
  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] GF_POLY   = 8'h1b;

  typedef logic [31:0] word_t;

  // AES forward S-box
  localparam logic [7:0] SBOX [0:255] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

endpackage
`default_nettype wire

// File: rtl/aes128_key_schedule.sv
`default_nettype none
// AES-128 key expansion. A key request is taken when start is high and busy
// is low; the block then emits the 44 schedule words W0..W43, one per clock,
// on out_* with out_valid high for one cycle each. The first word reaches the
// ports through the busy register and then the output registers, and the rest follow without
// gaps; out_last marks W43. The receiver cannot stall the stream, so it must
// take every word as it appears. busy stays high while the words of a key are
// being produced. The single word-wide S-box/XOR unit produces one schedule word
// per cycle from a four-word sliding window; a new key can be taken in the cycle
// busy drops, so a new key is never taken while a run is still in progress.
module aes128_key_schedule (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_key_high,
  input  wire logic [63:0] in_key_low,
  output logic             out_valid,
  output logic [5:0]       out_word_index,
  output logic [31:0]      out_round_word,
  output logic             out_last
);

  // Sequencer and window
  logic                      busy_r, busy_nxt;
  logic [aks_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]                rcon_r, rcon_nxt;
  aks_pkg::word_t            win_r [0:3];
  aks_pkg::word_t            win_nxt [0:3];

  logic                      vld_r, vld_nxt;
  logic [aks_pkg::IDX_W-1:0] idx_r;
  aks_pkg::word_t            word_r, word_nxt;
  logic                      last_r;

  logic           accept;
  logic           key_phase;
  logic           round_step;
  aks_pkg::word_t rot;
  aks_pkg::word_t feed;
  aks_pkg::word_t fresh;

  assign accept     = start && !busy_r;
  assign key_phase  = (cnt_r[aks_pkg::IDX_W-1:2] == '0);
  assign round_step = (cnt_r[1:0] == 2'b00);

  // Shared word unit: RotWord, SubWord, Rcon, XOR with W(i-4)
  always_comb begin
    rot = {win_r[3][23:0], win_r[3][31:24]};
    if (round_step) begin
      feed = {aks_pkg::SBOX[rot[31:24]] ^ rcon_r, aks_pkg::SBOX[rot[23:16]],
              aks_pkg::SBOX[rot[15:8]], aks_pkg::SBOX[rot[7:0]]};
    end else begin
      feed = win_r[3];
    end
    fresh = win_r[0] ^ feed;
  end

  // Next state
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rcon_nxt = rcon_r;
    vld_nxt  = 1'b0;
    word_nxt = word_r;
    for (int k = 0; k < 4; k++) win_nxt[k] = win_r[k];

    if (accept) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      rcon_nxt   = aks_pkg::RCON_INIT;
      win_nxt[0] = in_key_high[63:32];
      win_nxt[1] = in_key_high[31:0];
      win_nxt[2] = in_key_low[63:32];
      win_nxt[3] = in_key_low[31:0];
    end else if (busy_r) begin
      vld_nxt    = 1'b1;
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      win_nxt[2] = win_r[3];
      if (key_phase) begin
        // Key words pass out and rotate back into place
        word_nxt   = win_r[0];
        win_nxt[3] = win_r[0];
      end else begin
        word_nxt   = fresh;
        win_nxt[3] = fresh;
        if (round_step) begin
          rcon_nxt = {rcon_r[6:0], 1'b0} ^ (rcon_r[7] ? aks_pkg::GF_POLY : 8'h00);
        end
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == aks_pkg::LAST_IDX) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rcon_r <= rcon_nxt;
    for (int k = 0; k < 4; k++) win_r[k] <= win_nxt[k];
    word_r <= word_nxt;
    if (busy_r) begin
      idx_r  <= cnt_r;
      last_r <= (cnt_r == aks_pkg::LAST_IDX);
    end
  end

  assign busy           = busy_r;
  assign out_valid      = vld_r;
  assign out_word_index = idx_r;
  assign out_round_word = word_r;
  assign out_last       = vld_r && last_r;

  // Checks
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && (cnt_r == '0))
    else $error("request did not start a run");

  a_valid_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> $past(busy_r))
    else $error("word emitted outside a run");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> (idx_r == aks_pkg::LAST_IDX) && !busy_r)
    else $error("last flag on wrong word");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !last_r) |=> vld_r && (idx_r == $past(idx_r) + 1'b1))
    else $error("gap or skip in word stream");

endmodule
`default_nettype wire

// File: sim/aes128_key_schedule_tb.sv
`default_nettype none
module aes128_key_schedule_tb;

  localparam int         CLK_PERIOD   = 20;
  localparam int         RESET_CYCLES = 11;
  localparam int         NUM_WORDS    = 44;
  localparam int         NUM_RANDOM   = 200;
  localparam int         BURST_LEN    = 25;
  localparam int         DRAIN_CYCLES = 60;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         MAX_REPORTS  = 10;
  localparam logic [7:0] AES_POLY     = 8'h1b;
  localparam logic [7:0] AFFINE_C     = 8'h63;
  localparam logic [7:0] RCON_FIRST   = 8'h01;

  typedef struct {
    logic [63:0] key_high;
    logic [63:0] key_low;
    int          gap;      // idle cycles (busy low) before the request is raised
  } key_req_t;

  typedef struct {
    logic [5:0]  index;
    logic [31:0] word;
    logic        last;
  } sched_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [63:0] in_key_high = '0;
  logic [63:0] in_key_low = '0;
  logic        busy;
  logic        out_valid;
  logic [5:0]  out_word_index;
  logic [31:0] out_round_word;
  logic        out_last;

  key_req_t    key_reqs_q[$];
  sched_word_t sched_words_q[$];
  logic [7:0]  sbox_tab [0:255];
  int          keys_sent = 0;
  int          total_keys = 0;
  int          idle_cnt = 0;
  int          mismatch_cnt = 0;
  int          stall_cycles = 0;

  aes128_key_schedule u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_key_high    (in_key_high),
    .in_key_low     (in_key_low),
    .out_valid      (out_valid),
    .out_word_index (out_word_index),
    .out_round_word (out_round_word),
    .out_last       (out_last)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // GF(2^8) multiply, AES polynomial
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] prod;
    logic [7:0] acc;
    prod = 8'h00;
    acc  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) prod ^= acc;
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? AES_POLY : 8'h00);
    end
    return prod;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]], sbox_tab[w[7:0]]};
  endfunction

  // Expand one key into its 44 schedule words and queue them as expected output
  function automatic void push_schedule(input logic [63:0] key_high,
                                        input logic [63:0] key_low);
    logic [31:0] w [0:NUM_WORDS-1];
    logic [31:0] feed;
    logic [7:0]  rcon;
    sched_word_t sw;
    w[0] = key_high[63:32];
    w[1] = key_high[31:0];
    w[2] = key_low[63:32];
    w[3] = key_low[31:0];
    rcon = RCON_FIRST;
    for (int i = 4; i < NUM_WORDS; i++) begin
      feed = w[i-1];
      if (i % 4 == 0) begin
        feed = sub_word({feed[23:0], feed[31:24]}) ^ {rcon, 24'h000000};
        rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? AES_POLY : 8'h00);
      end
      w[i] = w[i-4] ^ feed;
    end
    for (int i = 0; i < NUM_WORDS; i++) begin
      sw.index = 6'(i);
      sw.word  = w[i];
      sw.last  = (i == NUM_WORDS - 1);
      sched_words_q.push_back(sw);
    end
  endfunction

  function automatic void add_req(input logic [63:0] key_high, input logic [63:0] key_low,
                                  input int gap);
    key_req_t req;
    req.key_high = key_high;
    req.key_low  = key_low;
    req.gap      = gap;
    key_reqs_q.push_back(req);
  endfunction

  // Request driver: holds start until accepted, then waits out the next gap
  always @(posedge clk) begin : drv
    logic     fire;
    key_req_t req;
    if (!rst_n) begin
      start    <= 1'b0;
      idle_cnt <= 0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        push_schedule(in_key_high, in_key_low);
        keys_sent++;
      end
      if (start && !fire) begin
        // request still pending, keep it on the bus
      end else if (key_reqs_q.size() != 0 && idle_cnt >= key_reqs_q[0].gap) begin
        req = key_reqs_q.pop_front();
        in_key_high <= req.key_high;
        in_key_low  <= req.key_low;
        start       <= 1'b1;
        idle_cnt    <= 0;
      end else begin
        start <= 1'b0;
        if (fire) idle_cnt <= 0;
        else if (!busy) idle_cnt <= idle_cnt + 1;
      end
    end
  end

  // Result monitor: every strobed word must match the oldest expected one
  always @(posedge clk) begin : mon
    sched_word_t exp_w;
    if (rst_n && out_valid) begin
      if (sched_words_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("ERROR: unexpected word idx=%0d word=%08h last=%0b",
                   out_word_index, out_round_word, out_last);
      end else begin
        exp_w = sched_words_q.pop_front();
        if (out_word_index !== exp_w.index || out_round_word !== exp_w.word ||
            out_last !== exp_w.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("ERROR: idx exp %0d got %0d, word exp %08h got %08h, last exp %0b got %0b",
                     exp_w.index, out_word_index, exp_w.word, out_round_word,
                     exp_w.last, out_last);
        end
      end
    end
  end

  // Watchdog on cycles with no request taken and no word delivered
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : main
    logic [7:0] inv;
    logic [7:0] s;
    int         gap;
    logic [63:0] mask;

    // S-box from the field inverse and the affine map
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(x));
      if (x == 0) inv = 8'h00;
      s = inv ^ AFFINE_C;
      for (int r = 1; r <= 4; r++) s ^= (inv << r) | (inv >> (8 - r));
      sbox_tab[x] = s;
    end

    // Directed keys: extremes, standard vector, bit patterns
    add_req(64'h0000000000000000, 64'h0000000000000000, 0);
    add_req(64'hffffffffffffffff, 64'hffffffffffffffff, 0);
    add_req(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 3);
    add_req(64'hffffffffffffffff, 64'h0000000000000000, 1);
    add_req(64'h0000000000000000, 64'hffffffffffffffff, 4);
    add_req(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 0);
    add_req(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 2);
    add_req(64'h8000000000000000, 64'h0000000000000001, 0);
    add_req(64'h0000000000000001, 64'h8000000000000000, 0);
    add_req(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1);
    add_req(64'h0123456789abcdef, 64'hfedcba9876543210, 0);
    add_req(64'h5252525252525252, 64'h5252525252525252, 4);

    // Random keys; alternate between stretches with and without sender gaps
    for (int i = 0; i < NUM_RANDOM; i++) begin
      gap = ((i / BURST_LEN) % 2 == 1) ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 4) == 0) begin
        mask = {$urandom, $urandom} & {$urandom, $urandom};
        add_req({$urandom, $urandom} & mask, {$urandom, $urandom} | ~mask, gap);
      end else begin
        add_req({$urandom, $urandom}, {$urandom, $urandom}, gap);
      end
    end
    total_keys = key_reqs_q.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (keys_sent < total_keys) @(posedge clk);
    while (sched_words_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
